// File: rtl/core/frp_pkg.sv
`default_nettype none

package frp_pkg;

  // Field widths of the item channels
  localparam int VA_W      = 20;
  localparam int PA_W      = 18;
  localparam int FRAME_W   = 6;
  localparam int EVP_W     = 8;
  localparam int CNT_W     = 32;
  localparam int OFS_W     = 12;
  localparam int SHIFT_W   = 4;

  // Page size limits (log2 of bytes)
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int FRAMES_W   = 7;
  localparam int VPAGES_W   = 9;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIRT_PAGES    = 2'd2;

  localparam logic [SHIFT_W-1:0]  PAGE_SHIFT_RST    = 4'd8;
  localparam logic [FRAMES_W-1:0] FRAMES_IN_USE_RST = 7'd64;
  localparam logic [VPAGES_W-1:0] VIRT_PAGES_RST    = 9'd256;

  // One page table entry: present bit and frame number
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Commands to the resident queue
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } q_cmd_t;

  // One result item
  typedef struct packed {
    logic [PA_W-1:0]    paddr;
    logic               fault;
    logic               evicted;
    logic [EVP_W-1:0]   evicted_page;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   fault_total;
    logic               range_error;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT
  } frp_state_t;

endpackage

`default_nettype wire

// File: rtl/core/frp_page_table.sv
`default_nettype none

module frp_page_table #(
  parameter int MAX_PAGES = 256,
  parameter int PW        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [PW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [PW-1:0]     wr_addr,
  input  frp_pkg::entry_t   wr_data,
  output frp_pkg::entry_t   rd_data,
  output logic              ready
);
  import frp_pkg::*;

  entry_t          mem [MAX_PAGES];
  entry_t          rd_data_r;
  logic            clr_busy_r, clr_busy_nxt;
  logic [PW-1:0]   clr_idx_r, clr_idx_nxt;
  logic            mem_we;
  logic [PW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  // Sweep every entry to absent after reset
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + PW'(1);
      if (clr_idx_r == PW'(MAX_PAGES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // Steer the write port to the sweep while it runs
  assign mem_we    = clr_busy_r | wr_en;
  assign mem_waddr = clr_busy_r ? clr_idx_r : wr_addr;
  assign mem_wdata = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ~clr_busy_r;

endmodule

`default_nettype wire

// File: rtl/core/frp_res_queue.sv
`default_nettype none

module frp_res_queue #(
  parameter int MAX_FRAMES = 64,
  parameter int PW         = 8,
  parameter int CW         = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  frp_pkg::q_cmd_t             cmd,
  input  logic [PW-1:0]               push_page,
  input  logic [frp_pkg::FRAME_W-1:0] push_frame,
  output logic [PW-1:0]               head_page,
  output logic [frp_pkg::FRAME_W-1:0] head_frame,
  output logic [CW-1:0]               count
);
  import frp_pkg::*;

  localparam int HW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SW = CW + 1;
  localparam int DW = PW + FRAME_W;

  // Each slot holds a resident page and the frame it occupies
  logic [DW-1:0]  mem [MAX_FRAMES];
  logic [DW-1:0]  rd_data_r;
  logic [HW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  tail_sum;
  logic [SW-1:0]  tail_wrap;
  logic [HW-1:0]  tail_slot;

  // Place the new page behind the current tail, wrapping once
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail_wrap = (tail_sum >= SW'(MAX_FRAMES)) ? tail_sum - SW'(MAX_FRAMES) : tail_sum;
  assign tail_slot = tail_wrap[HW-1:0];

  // Advance head on pop, adjust count on push and pop
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt = (head_r == HW'(MAX_FRAMES - 1)) ? '0 : head_r + HW'(1);
    end
    if (cmd.push && !cmd.pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!cmd.push && cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_slot] <= {push_page, push_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign head_page  = rd_data_r[DW-1:FRAME_W];
  assign head_frame = rd_data_r[FRAME_W-1:0];
  assign count      = count_r;

endmodule

`default_nettype wire

// File: rtl/core/frp_ctrl.sv
`default_nettype none

module frp_ctrl #(
  parameter int PW = 8,
  parameter int CW = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  input  logic [frp_pkg::VA_W-1:0]    in_addr,
  input  logic [frp_pkg::SHIFT_W-1:0] shift,
  input  logic [frp_pkg::VA_W-1:0]    page_limit,
  input  logic [CW-1:0]               frame_limit,
  input  logic                        pt_ready,
  input  frp_pkg::entry_t             pt_rd_data,
  input  logic [PW-1:0]               q_head_page,
  input  logic [frp_pkg::FRAME_W-1:0] q_head_frame,
  input  logic [CW-1:0]               q_count,
  input  logic                        out_free,
  output logic                        busy,
  output logic                        pt_rd_en,
  output logic [PW-1:0]               pt_rd_addr,
  output logic                        pt_wr_en,
  output logic [PW-1:0]               pt_wr_addr,
  output frp_pkg::entry_t             pt_wr_data,
  output frp_pkg::q_cmd_t             q_cmd,
  output logic [PW-1:0]               q_push_page,
  output logic [frp_pkg::FRAME_W-1:0] q_push_frame,
  output logic                        res_valid,
  output frp_pkg::res_t               res
);
  import frp_pkg::*;

  frp_state_t         state_r, state_nxt;
  logic [PW-1:0]      page_r, page_nxt;
  logic [OFS_W-1:0]   offset_r, offset_nxt;
  logic               range_r, range_nxt;
  logic [PW-1:0]      victim_r, victim_nxt;
  logic [CNT_W-1:0]   fault_cnt_r, fault_cnt_nxt;

  logic [VA_W-1:0]    page_full;
  logic [VA_W-1:0]    offset_full;
  logic               range_err;
  logic               hit;
  logic               fault;
  logic               evict;
  logic [FRAME_W-1:0] fresh_frame;
  logic [FRAME_W-1:0] frame;
  logic               finish;

  // Split the address into page index and offset
  assign page_full   = in_addr >> shift;
  assign offset_full = in_addr & ~({VA_W{1'b1}} << shift);
  assign range_err   = page_full >= page_limit;

  // Classify the access once the table entry is back
  assign hit         = pt_rd_data.present;
  assign fault       = ~range_r & ~hit;
  assign evict       = fault & (q_count >= frame_limit);
  // Frames handed out always equals the queue fill, so count down from it
  assign fresh_frame = FRAME_W'(frame_limit - CW'(1) - q_count);
  assign frame       = range_r ? '0 :
                       hit     ? pt_rd_data.frame :
                       evict   ? q_head_frame : fresh_frame;
  assign finish      = (state_r == ST_LOOKUP) & out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (out_free) state_nxt = evict ? ST_EVICT : ST_IDLE;
      end
      ST_EVICT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory commands and result
  always_comb begin
    pt_rd_en     = 1'b0;
    pt_rd_addr   = page_full[PW-1:0];
    pt_wr_en     = 1'b0;
    pt_wr_addr   = page_r;
    pt_wr_data   = '{present: 1'b1, frame: frame};
    q_cmd        = '{rd: 1'b0, push: 1'b0, pop: 1'b0};
    q_push_page  = page_r;
    q_push_frame = frame;
    res_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        pt_rd_en = in_accept & ~range_err;
        q_cmd.rd = in_accept;
      end
      ST_LOOKUP: begin
        res_valid  = out_free;
        pt_wr_en   = out_free & fault;
        q_cmd.push = out_free & fault;
        q_cmd.pop  = out_free & evict;
      end
      ST_EVICT: begin
        pt_wr_en   = 1'b1;
        pt_wr_addr = victim_r;
        pt_wr_data = '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res.paddr        = range_r ? '0 : ((PA_W'(frame) << shift) | PA_W'(offset_r));
  assign res.fault        = fault;
  assign res.evicted      = evict;
  assign res.evicted_page = evict ? EVP_W'(q_head_page) : '0;
  assign res.frame        = frame;
  assign res.fault_total  = fault ? fault_cnt_r + CNT_W'(1) : fault_cnt_r;
  assign res.range_error  = range_r;

  assign busy = (state_r != ST_IDLE) | ~pt_ready;

  // Capture the item on accept, the victim and the count on completion
  always_comb begin
    page_nxt      = page_r;
    offset_nxt    = offset_r;
    range_nxt     = range_r;
    victim_nxt    = victim_r;
    fault_cnt_nxt = fault_cnt_r;
    if (in_accept) begin
      page_nxt   = page_full[PW-1:0];
      offset_nxt = offset_full[OFS_W-1:0];
      range_nxt  = range_err;
    end
    if (finish) begin
      victim_nxt    = q_head_page;
      fault_cnt_nxt = res.fault_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fault_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      fault_cnt_r <= fault_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    offset_r <= offset_nxt;
    range_r  <= range_nxt;
    victim_r <= victim_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/fifo_page_replacement_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_*      in         in_valid / in_stall  in_virt_addr
// out_*     out        out_valid / out_stall out_phys_addr, out_fault, out_evicted,
//                                           out_evicted_page, out_frame,
//                                           out_fault_total, out_range_error
// cfg_*     in         cfg_wr_en            cfg_index, cfg_data
//
// A hit, a range error or a fault on a free frame passes ST_IDLE and ST_LOOKUP; a
// fault that evicts also passes ST_EVICT, which clears the victim through the page
// table's single write port. After reset the page table is swept to absent, with
// in_stall high. A result waits in the output register under out_stall while the
// next item is accepted; the lookup then holds until it frees.
module fifo_page_replacement_top #(
  parameter int MAX_PAGES  = 256,
  parameter int MAX_FRAMES = 64,
  parameter int VADDR_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [frp_pkg::VA_W-1:0]       in_virt_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [frp_pkg::PA_W-1:0]       out_phys_addr,
  output logic                           out_fault,
  output logic                           out_evicted,
  output logic [frp_pkg::EVP_W-1:0]      out_evicted_page,
  output logic [frp_pkg::FRAME_W-1:0]    out_frame,
  output logic [frp_pkg::CNT_W-1:0]      out_fault_total,
  output logic                           out_range_error,
  input  logic                           cfg_wr_en,
  input  logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import frp_pkg::*;

  localparam int PW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int NW = (CW > FRAMES_W) ? CW : FRAMES_W;
  localparam int VB = (VADDR_BITS < VA_W) ? VADDR_BITS : VA_W;
  localparam logic [VA_W-1:0] VMASK = VA_W'((64'd1 << VB) - 64'd1);

  logic [SHIFT_W-1:0]  page_shift_r;
  logic [FRAMES_W-1:0] frames_r;
  logic [VPAGES_W-1:0] vpages_r;

  logic [SHIFT_W-1:0]  eff_shift;
  logic [NW-1:0]       frames_w;
  logic [NW-1:0]       eff_frames_w;
  logic [CW-1:0]       frame_limit;
  logic [VA_W-1:0]     vpages_w;
  logic [VA_W-1:0]     page_limit;

  logic                in_accept;
  logic                busy;
  logic                out_free;
  logic                pt_rd_en;
  logic [PW-1:0]       pt_rd_addr;
  logic                pt_wr_en;
  logic [PW-1:0]       pt_wr_addr;
  entry_t              pt_wr_data;
  entry_t              pt_rd_data;
  logic                pt_ready;
  q_cmd_t              q_cmd;
  logic [PW-1:0]       q_push_page;
  logic [FRAME_W-1:0]  q_push_frame;
  logic [PW-1:0]       q_head_page;
  logic [FRAME_W-1:0]  q_head_frame;
  logic [CW-1:0]       q_count;
  logic                res_valid;
  res_t                res;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= PAGE_SHIFT_RST;
      frames_r     <= FRAMES_IN_USE_RST;
      vpages_r     <= VIRT_PAGES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAGE_SHIFT:    page_shift_r <= cfg_data[SHIFT_W-1:0];
        REG_FRAMES_IN_USE: frames_r     <= cfg_data[FRAMES_W-1:0];
        REG_VIRT_PAGES:    vpages_r     <= cfg_data[VPAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration to what the hardware holds
  assign eff_shift    = (page_shift_r < SHIFT_MIN) ? SHIFT_MIN :
                        (page_shift_r > SHIFT_MAX) ? SHIFT_MAX : page_shift_r;
  assign frames_w     = NW'(frames_r);
  assign eff_frames_w = (frames_w == '0) ? NW'(1) :
                        (frames_w > NW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : frames_w;
  assign frame_limit  = eff_frames_w[CW-1:0];
  assign vpages_w     = VA_W'(vpages_r);
  assign page_limit   = (vpages_w > VA_W'(MAX_PAGES)) ? VA_W'(MAX_PAGES) : vpages_w;

  assign in_stall  = busy;
  assign in_accept = in_valid & ~busy;
  assign out_free  = ~out_valid_r | ~out_stall;

  frp_page_table #(
    .MAX_PAGES (MAX_PAGES),
    .PW        (PW)
  ) u_page_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (pt_rd_en),
    .rd_addr (pt_rd_addr),
    .wr_en   (pt_wr_en),
    .wr_addr (pt_wr_addr),
    .wr_data (pt_wr_data),
    .rd_data (pt_rd_data),
    .ready   (pt_ready)
  );

  frp_res_queue #(
    .MAX_FRAMES (MAX_FRAMES),
    .PW         (PW),
    .CW         (CW)
  ) u_res_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_cmd),
    .push_page  (q_push_page),
    .push_frame (q_push_frame),
    .head_page  (q_head_page),
    .head_frame (q_head_frame),
    .count      (q_count)
  );

  frp_ctrl #(
    .PW (PW),
    .CW (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_addr      (in_virt_addr & VMASK),
    .shift        (eff_shift),
    .page_limit   (page_limit),
    .frame_limit  (frame_limit),
    .pt_ready     (pt_ready),
    .pt_rd_data   (pt_rd_data),
    .q_head_page  (q_head_page),
    .q_head_frame (q_head_frame),
    .q_count      (q_count),
    .out_free     (out_free),
    .busy         (busy),
    .pt_rd_en     (pt_rd_en),
    .pt_rd_addr   (pt_rd_addr),
    .pt_wr_en     (pt_wr_en),
    .pt_wr_addr   (pt_wr_addr),
    .pt_wr_data   (pt_wr_data),
    .q_cmd        (q_cmd),
    .q_push_page  (q_push_page),
    .q_push_frame (q_push_frame),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Output register: load a finished item, drop it once taken
  assign out_valid_nxt = res_valid | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phys_addr    = out_res_r.paddr;
  assign out_fault        = out_res_r.fault;
  assign out_evicted      = out_res_r.evicted;
  assign out_evicted_page = out_res_r.evicted_page;
  assign out_frame        = out_res_r.frame;
  assign out_fault_total  = out_res_r.fault_total;
  assign out_range_error  = out_res_r.range_error;

  // Checks
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    !pt_ready |-> in_stall)
    else $error("item accepted during page table sweep");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_fault && !out_range_error)
    else $error("eviction without a fault");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(MAX_FRAMES))
    else $error("resident queue overfilled");

  a_no_write_on_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.range_error |-> !pt_wr_en && !q_cmd.push)
    else $error("out-of-range page changed state");

endmodule

`default_nettype wire
